>>> sv/pwl_pkg.sv
// ----------------------------------------------------------------------------
// pwl_pkg
// Shared types and codes of the piecewise linear lookup core.
// ----------------------------------------------------------------------------
`default_nettype none

package pwl_pkg;

  localparam int unsigned ValW = 32;
  localparam int unsigned ProdW = 64;

  typedef logic [1:0] status_t;
  localparam status_t StatusOk    = 2'd0;
  localparam status_t StatusBelow = 2'd1;
  localparam status_t StatusAbove = 2'd2;

  typedef logic signed [ValW-1:0] val_t;

  typedef struct packed {
    logic             start;
    logic [ProdW-1:0] dividend;
    logic [ValW:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [ProdW-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

>>> sv/pwl_divider.sv
// ----------------------------------------------------------------------------
// pwl_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pwl_divider import pwl_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  localparam int unsigned CntW = $clog2(ProdW);

  logic [ProdW-1:0] quo_q, quo_d;
  logic [ValW:0]    rem_q, rem_d;
  logic [ValW:0]    dsr_q, dsr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [ValW+1:0]  trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[ProdW-1]} - {1'b0, dsr_q};
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[ValW+1]) begin
        rem_d = trial[ValW:0];
        quo_d = {quo_q[ProdW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[ValW-1:0], quo_q[ProdW-1]};
        quo_d = {quo_q[ProdW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(ProdW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

>>> sv/piecewise_linear_lookup_core.sv
// ----------------------------------------------------------------------------
// piecewise_linear_lookup_core
// Table of Q16.16 points with binary search and linear interpolation.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake        Payload
// in       input      valid / stall    action, point_index, x_value, y_value
// out      output     valid / stall    y_result, status
// cfg      input      valid / ready    points_in_use
//
// A write passes through StWrite before its result is presented in StOut. An
// evaluation spends StSearch, StSRead and StSCmp on each search step and a last
// StSearch to end it; an argument in range then reads both points and forms the
// product in StRd0, StRd1, StRdWait and StMul, starts and runs the bit-serial
// divide in StDiv and StDivWait and adds in StSum before StOut.
// Reset clears the control state and points_in_use; table entries are
// undefined until written. The block takes no item until its result has been
// transferred.
`default_nettype none

module piecewise_linear_lookup_core import pwl_pkg::*; #(
  parameter int unsigned MAX_POINTS = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        action_i,
  input  wire logic [7:0]  point_index_i,
  input  wire logic signed [31:0] x_value_i,
  input  wire logic signed [31:0] y_value_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic signed [31:0] y_result_o,
  output logic [1:0]       status_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [8:0]  cfg_data_i
);

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned NW = $clog2(MAX_POINTS + 1);

  typedef enum logic [3:0] {
    StIdle, StWrite, StSearch, StSRead, StSCmp, StRd0, StRd1, StRdWait,
    StMul, StDiv, StDivWait, StSum, StOut
  } state_e;

  logic [ValW-1:0] mem_x [MAX_POINTS];
  logic [ValW-1:0] mem_y [MAX_POINTS];

  state_e          state_q;
  logic [8:0]      npts_q;
  logic [NW-1:0]   n_q, lo_q, hi_q, mid_q;
  logic [AW-1:0]   addr_q;
  logic            wr_ok_q;
  val_t            a_q, yin_q;
  val_t            rd_x_q, rd_y_q;
  val_t            x0_q, y0_q, x1_q, y1_q;
  logic [ProdW-1:0] prod_q;
  logic            neg_q;
  logic [ValW:0]   den_q;
  logic            den_zero_q;
  logic [ValW-1:0] res_q;
  status_t         st_q;
  logic            rd_en;
  div_req_t        dreq;
  div_rsp_t        drsp;

  logic [ValW:0] dx, dy, dd;
  logic [ValW-1:0] mdx, mdy;
  logic [ValW:0] mdd;
  logic [ProdW-1:0] qsigned;

  assign dx  = {a_q[ValW-1], a_q} - {x0_q[ValW-1], x0_q};
  assign dy  = {y1_q[ValW-1], y1_q} - {y0_q[ValW-1], y0_q};
  assign dd  = {x1_q[ValW-1], x1_q} - {x0_q[ValW-1], x0_q};
  assign mdx = dx[ValW] ? ValW'(-dx) : dx[ValW-1:0];
  assign mdy = dy[ValW] ? ValW'(-dy) : dy[ValW-1:0];
  assign mdd = dd[ValW] ? -dd : dd;
  assign qsigned = neg_q ? -drsp.quotient : drsp.quotient;

  assign in_stall_o  = (state_q != StIdle);
  assign cfg_ready_o = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign y_result_o  = res_q;
  assign status_o    = st_q;

  assign rd_en = (state_q == StSRead) || (state_q == StRd0) || (state_q == StRd1);

  always_ff @(posedge clk_i) begin
    if (state_q == StWrite && wr_ok_q) begin
      mem_x[addr_q] <= a_q;
      mem_y[addr_q] <= yin_q;
    end
    if (rd_en) begin
      rd_x_q <= mem_x[addr_q];
      rd_y_q <= mem_y[addr_q];
    end
  end

  always_comb begin
    dreq.start    = (state_q == StDiv);
    dreq.dividend = prod_q;
    dreq.divisor  = den_q;
  end

  pwl_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      npts_q  <= '0;
      st_q    <= StatusOk;
      res_q   <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (cfg_valid_i) begin
            npts_q <= cfg_data_i;
          end
          if (in_valid_i) begin
            addr_q  <= AW'(point_index_i);
            wr_ok_q <= (32'(point_index_i) < MAX_POINTS);
            a_q     <= x_value_i;
            yin_q   <= y_value_i;
            lo_q    <= '0;
            if (32'(npts_q) > MAX_POINTS) begin
              n_q  <= NW'(MAX_POINTS);
              hi_q <= NW'(MAX_POINTS);
            end else begin
              n_q  <= NW'(npts_q);
              hi_q <= NW'(npts_q);
            end
            state_q <= action_i ? StSearch : StWrite;
          end
        end
        StWrite: begin
          res_q   <= '0;
          st_q    <= StatusOk;
          state_q <= StOut;
        end
        StSearch: begin
          if (lo_q < hi_q) begin
            mid_q   <= lo_q + ((hi_q - lo_q) >> 1);
            addr_q  <= AW'(lo_q + ((hi_q - lo_q) >> 1));
            state_q <= StSRead;
          end else if (lo_q == '0) begin
            res_q   <= '0;
            st_q    <= StatusBelow;
            state_q <= StOut;
          end else if (lo_q == n_q) begin
            res_q   <= '0;
            st_q    <= StatusAbove;
            state_q <= StOut;
          end else begin
            addr_q  <= AW'(lo_q - 1'b1);
            state_q <= StRd0;
          end
        end
        StSRead: begin
          state_q <= StSCmp;
        end
        StSCmp: begin
          if ($signed(rd_x_q) > $signed(a_q)) begin
            hi_q <= mid_q;
          end else begin
            lo_q <= mid_q + 1'b1;
          end
          state_q <= StSearch;
        end
        StRd0: begin
          addr_q  <= AW'(lo_q);
          state_q <= StRd1;
        end
        StRd1: begin
          x0_q    <= rd_x_q;
          y0_q    <= rd_y_q;
          state_q <= StRdWait;
        end
        StRdWait: begin
          x1_q    <= rd_x_q;
          y1_q    <= rd_y_q;
          state_q <= StMul;
        end
        StMul: begin
          prod_q     <= ProdW'(mdx) * ProdW'(mdy);
          neg_q      <= (dx[ValW] ^ dy[ValW]) ^ dd[ValW];
          den_q      <= mdd;
          den_zero_q <= (dd == '0);
          state_q    <= StDiv;
        end
        StDiv: begin
          state_q <= StDivWait;
        end
        StDivWait: begin
          if (drsp.done) begin
            state_q <= StSum;
          end
        end
        StSum: begin
          res_q   <= den_zero_q ? y0_q : y0_q + qsigned[ValW-1:0];
          st_q    <= StatusOk;
          state_q <= StOut;
        end
        StOut: begin
          if (!out_stall_i) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StatusOk |-> y_result_o == '0)
    else $error("out of range result is not zero");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StSCmp |-> lo_q <= hi_q && hi_q <= n_q)
    else $error("search bounds out of order");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(y_result_o))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while result pending");

endmodule

`default_nettype wire

>>> test/tb_piecewise_linear_lookup_core.sv
// ----------------------------------------------------------------------------
// tb_piecewise_linear_lookup_core
// Loads sample tables, evaluates arguments across them and compares every
// result transfer with a predicted value, under random gaps and stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_piecewise_linear_lookup_core;
  import pwl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NPTS = 256;
  localparam logic ActWrite = 1'b0;
  localparam logic ActEval  = 1'b1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic action_i = 1'b0;
  logic [7:0] point_index_i = '0;
  logic signed [31:0] x_value_i = '0;
  logic signed [31:0] y_value_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] y_result_o;
  logic [1:0] status_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [8:0] cfg_data_i = '0;

  piecewise_linear_lookup_core #(.MAX_POINTS(NPTS)) uut (.*);

  always #6 clk_i = ~clk_i;

  typedef struct packed {
    val_t    y;
    status_t st;
  } lookup_res_t;

  val_t        x_tab [NPTS];
  val_t        y_tab [NPTS];
  logic [8:0]  pts_in_use = '0;
  lookup_res_t lookup_q [$];
  int          errors = 0;
  int          n_results = 0;
  int          n_items = 0;
  bit          hold_off = 1'b0;
  bit          long_stall = 1'b0;
  int          n_sorted;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic lookup_res_t predict_lookup(input logic act, input logic [7:0] idx,
                                                 input val_t xv, input val_t yv);
    lookup_res_t r;
    int unsigned n, lo, hi, mid;
    longint dx, dy, den;
    longint unsigned prod, q;
    bit neg;
    r = '0;
    if (act == ActWrite) begin
      x_tab[idx] = xv;
      y_tab[idx] = yv;
      return r;
    end
    n = (pts_in_use > NPTS) ? NPTS : pts_in_use;
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (x_tab[mid] > xv) hi = mid;
      else lo = mid + 1;
    end
    if (lo == 0) r.st = StatusBelow;
    else if (lo == n) r.st = StatusAbove;
    else begin
      dx = longint'(xv) - longint'(x_tab[lo-1]);
      dy = longint'(y_tab[lo]) - longint'(y_tab[lo-1]);
      den = longint'(x_tab[lo]) - longint'(x_tab[lo-1]);
      q = 0;
      if (den != 0) begin
        prod = longint'(dx < 0 ? -dx : dx) * longint'(dy < 0 ? -dy : dy);
        neg = ((dx < 0) != (dy < 0)) != (den < 0);
        q = prod / longint'(den < 0 ? -den : den);
        if (neg) q = -q;
      end
      r.y = val_t'(longint'(y_tab[lo-1]) + q);
      r.st = StatusOk;
    end
    return r;
  endfunction

  task automatic random_gap();
    int g;
    g = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
    repeat (g) @(negedge clk_i);
  endtask

  task automatic send_item(input logic act, input logic [7:0] idx,
                           input val_t xv, input val_t yv);
    while (hold_off) @(negedge clk_i);
    in_valid_i <= 1'b1;
    action_i <= act;
    point_index_i <= idx;
    x_value_i <= xv;
    y_value_i <= yv;
    do @(posedge clk_i); while (in_stall_o);
    lookup_q.push_back(predict_lookup(act, idx, xv, yv));
    n_items++;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    random_gap();
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (lookup_q.size() != 0 && guard < 200000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (120) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [8:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    pts_in_use = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Loads n points with strictly increasing x and returns nothing; tables stay sorted.
  task automatic load_sorted(input int n, input int step_max);
    val_t xv;
    xv = val_t'(-$urandom_range(0, 32'h7000_0000));
    for (int i = 0; i < n; i++) begin
      send_item(ActWrite, 8'(i), xv, val_t'($urandom));
      xv = xv + val_t'($urandom_range(1, step_max));
    end
    n_sorted = n;
  endtask

  function automatic val_t pick_arg();
    int k;
    k = $urandom_range(0, n_sorted - 1);
    case ($urandom_range(0, 5))
      0: return x_tab[k];
      1: return x_tab[k] - 1;
      2: return x_tab[k] + 1;
      3: return val_t'($urandom);
      default: return x_tab[k] + val_t'($urandom_range(0, 4000));
    endcase
  endfunction

  task automatic test_directed();
    write_cfg(9'd0);
    send_item(ActEval, 8'h00, 32'sh0, 32'sh0);
    send_item(ActWrite, 8'd0, 32'sh8000_0000, 32'sh7fff_ffff);
    send_item(ActWrite, 8'd1, 32'sh0, 32'sh8000_0000);
    send_item(ActWrite, 8'd2, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_item(ActWrite, 8'd3, 32'sh7fff_ffff, 32'sh0);
    send_item(ActWrite, 8'd255, 32'sh1234_5678, 32'shffff_ffff);
    write_cfg(9'd3);
    send_item(ActEval, 8'hff, 32'sh8000_0000, 32'shffff_ffff);
    send_item(ActEval, 8'h00, 32'sh8000_0001, 32'sh0);
    send_item(ActEval, 8'h00, 32'shffff_ffff, 32'sh0);
    send_item(ActEval, 8'h00, 32'sh0, 32'sh0);
    send_item(ActEval, 8'h00, 32'sh7fff_fffe, 32'sh0);
    send_item(ActEval, 8'h00, 32'sh7fff_ffff, 32'sh0);
    write_cfg(9'd4);
    send_item(ActEval, 8'h00, 32'sh7fff_fffe, 32'sh0);
    write_cfg(9'd2);
    send_item(ActEval, 8'h00, 32'sh8000_0000, 32'sh0);
    // Non-increasing table: an equal step.
    send_item(ActWrite, 8'd0, 32'sh0001_0000, 32'sh0000_0100);
    send_item(ActWrite, 8'd1, 32'sh0001_0000, 32'sh0500_0000);
    send_item(ActEval, 8'h00, 32'sh0000_0000, 32'sh0);
    send_item(ActEval, 8'h00, 32'sh0001_0000, 32'sh0);
  endtask

  task automatic test_full_table();
    load_sorted(NPTS, 32'h0080_0000);
    write_cfg(9'd256);
    repeat (60) send_item(ActEval, 8'($urandom), pick_arg(), val_t'($urandom));
    write_cfg(9'd511);
    repeat (30) send_item(ActEval, 8'($urandom), pick_arg(), val_t'($urandom));
  endtask

  task automatic test_random();
    int n;
    for (int ph = 0; ph < 14; ph++) begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(2, NPTS) : $urandom_range(2, 12);
      load_sorted(n, ($urandom_range(0, 1) != 0) ? 32'h0001_0000 : 32'h3fff_ffff / n);
      write_cfg(9'($urandom_range(1, n)));
      repeat ($urandom_range(40, 60)) begin
        if ($urandom_range(0, 9) == 0)
          send_item(ActWrite, 8'($urandom_range(n, NPTS - 1)), val_t'($urandom),
                    val_t'($urandom));
        else
          send_item(ActEval, 8'($urandom), pick_arg(), val_t'($urandom));
      end
    end
  endtask

  task automatic test_pressure();
    long_stall = 1'b1;
    repeat (8) send_item(ActEval, 8'($urandom), pick_arg(), '0);
    long_stall = 1'b0;
    drain();
    hold_off = 1'b1;
    repeat (50) @(negedge clk_i);
    hold_off = 1'b0;
    repeat (8) send_item(ActEval, 8'($urandom), pick_arg(), '0);
  endtask

  always @(posedge clk_i) begin
    lookup_res_t w;
    if (out_valid_o && !out_stall_i) begin
      n_results++;
      if (lookup_q.size() == 0) begin
        report_mismatch("unexpected result", y_result_o, '0);
      end else begin
        w = lookup_q.pop_front();
        if (y_result_o !== w.y) report_mismatch("y_result", y_result_o, w.y);
        if (status_o !== w.st) report_mismatch("status", 32'(status_o), 32'(w.st));
      end
    end
  end

  initial begin
    int g;
    forever begin
      @(negedge clk_i);
      if (long_stall) begin
        out_stall_i <= 1'b1;
        repeat (400) @(negedge clk_i);
        out_stall_i <= 1'b0;
        wait (!long_stall);
      end else begin
        g = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 80) : $urandom_range(0, 2);
        if ($urandom_range(0, 2) == 0) g = 0;
        if (g != 0) begin
          out_stall_i <= 1'b1;
          repeat (g) @(negedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  initial begin
    #40ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);
    test_directed();
    test_full_table();
    test_random();
    test_pressure();
    drain();
    $display("Covered %0d items and %0d results: extremes, empty, full and oversized tables,",
             n_items, n_results);
    $display("unsorted points, random searches under stalls and a long output hold-off.");
    if (errors == 0 && lookup_q.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

`default_nettype wire
